// ===== hdl/apvo_pkg.sv =====
// Shared types, constants and helper functions of the additive piano voice.
`default_nettype none

package apvo_pkg;

    localparam int STEP_W   = 32;
    localparam int DECAY_W  = 24;
    localparam int LEVEL_W  = 19;
    localparam int LOUD_W   = 17;
    localparam int ENV_W    = 25;
    localparam int ACC_W    = 25;
    localparam int TONE_W   = 21;
    localparam int SINE_W   = 16;
    localparam int MAG_W    = 15;
    localparam int WEIGHT_W = 8;
    localparam int OPA_W    = 34;
    localparam int OPB_W    = 26;
    localparam int PROD_W   = 60;
    localparam int CFG_AW   = 4;
    localparam int CFG_DW   = 32;

    localparam logic [ENV_W-1:0]   ENV_ONE        = 25'h100_0000;
    localparam logic [STEP_W-1:0]  RST_PHASE_STEP = 32'd0;
    localparam logic [DECAY_W-1:0] RST_DECAY      = 24'hFF_FFFF;
    localparam logic [LEVEL_W-1:0] RST_LEVEL      = 19'd3277;
    localparam logic [LOUD_W-1:0]  RST_LOUD       = 17'd22938;

    localparam logic [WEIGHT_W-1:0] WEIGHT_TOP = 8'd128;

    localparam logic signed [PROD_W-1:0] SAT_POS    = 60'sd32767;
    localparam logic signed [PROD_W-1:0] SAT_NEG    = -60'sd32767;
    localparam logic signed [SINE_W-1:0] SAMPLE_POS = 16'sd32767;
    localparam logic signed [SINE_W-1:0] SAMPLE_NEG = -16'sd32767;

    typedef enum logic [1:0] {
        REG_PHASE_STEP,
        REG_DECAY,
        REG_LEVEL,
        REG_LOUD
    } t_reg_idx;

    typedef struct packed {
        logic [STEP_W-1:0]  phase_step;
        logic [DECAY_W-1:0] decay_factor;
        logic [LEVEL_W-1:0] overdrive_level;
        logic [LOUD_W-1:0]  loudness;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROM,
        S_MUL,
        S_ACC,
        S_ENV,
        S_TONE,
        S_SQ,
        S_CUBE,
        S_SHAPE,
        S_CLAMP,
        S_GAIN,
        S_OUT,
        S_DMUL,
        S_DECAY
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_HARM,
        MUL_ENV,
        MUL_SQ,
        MUL_CUBE,
        MUL_GAIN,
        MUL_DECAY
    } t_mul_op;

    typedef struct packed {
        logic    in_ready;
        logic    start;
        logic    hp_adv;
        logic    acc_add;
        logic    h_inc;
        logic    tone_ld;
        logic    shape_ld;
        logic    clamp_ld;
        logic    out_ld;
        logic    env_upd;
        t_mul_op mul_op;
    } t_ctrl;

    // Divide by 2^n with rounding half away from zero, using a single add.
    function automatic logic signed [PROD_W-1:0] rnd_shift(
        input logic signed [PROD_W-1:0] v,
        input int                       n
    );
        logic signed [PROD_W-1:0] half;
        logic signed [PROD_W-1:0] bias;
        half = PROD_W'(1) <<< (n - 1);
        bias = half - PROD_W'(v[PROD_W-1]);
        return (v + bias) >>> n;
    endfunction

    // Quarter-wave sine entry, evaluated at elaboration from a Taylor series.
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned idx, input int tb);
        longint x;
        longint x2;
        longint term;
        longint s;
        longint v;
        x    = longint'((64'd1686629713 * 64'(idx)) >> tb);
        x2   = (x * x) >>> 30;
        term = x;
        s    = x;
        term = ((term * x2) >>> 30) / 6;
        s    = s - term;
        term = ((term * x2) >>> 30) / 20;
        s    = s + term;
        term = ((term * x2) >>> 30) / 42;
        s    = s - term;
        term = ((term * x2) >>> 30) / 72;
        s    = s + term;
        term = ((term * x2) >>> 30) / 110;
        s    = s - term;
        term = ((term * x2) >>> 30) / 156;
        s    = s + term;
        term = ((term * x2) >>> 30) / 210;
        s    = s - term;
        if (s < 0) begin
            s = 0;
        end
        v = (s * 32767 + (longint'(1) <<< 29)) >>> 30;
        if (v > 32767) begin
            v = 32767;
        end
        return MAG_W'(v);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/apvo_stream_if.sv =====
// Valid/ready stream interfaces for the note input and the sample output.
`default_nettype none

interface apvo_in_if;
    logic valid;
    logic ready;
    logic note_start;

    modport source (output valid, output note_start, input ready);
    modport sink   (input valid, input note_start, output ready);
endinterface

interface apvo_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [15:0]       sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== hdl/apvo_cfg_regs.sv =====
// APB-style configuration register file of the voice.
`default_nettype none

module apvo_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [apvo_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [apvo_pkg::CFG_DW-1:0]   pwdata,
    output logic      [apvo_pkg::CFG_DW-1:0]   prdata,
    output logic                               pready,
    output apvo_pkg::t_cfg                     o_cfg
);

    apvo_pkg::t_cfg   r_cfg;
    apvo_pkg::t_cfg   n_cfg;
    apvo_pkg::t_reg_idx sel;
    logic             wr_en;

    assign sel    = apvo_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (sel)
                apvo_pkg::REG_PHASE_STEP: n_cfg.phase_step      = pwdata;
                apvo_pkg::REG_DECAY:      n_cfg.decay_factor    = pwdata[apvo_pkg::DECAY_W-1:0];
                apvo_pkg::REG_LEVEL:      n_cfg.overdrive_level = pwdata[apvo_pkg::LEVEL_W-1:0];
                apvo_pkg::REG_LOUD:       n_cfg.loudness        = pwdata[apvo_pkg::LOUD_W-1:0];
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (sel)
            apvo_pkg::REG_PHASE_STEP: prdata = r_cfg.phase_step;
            apvo_pkg::REG_DECAY:      prdata = apvo_pkg::CFG_DW'(r_cfg.decay_factor);
            apvo_pkg::REG_LEVEL:      prdata = apvo_pkg::CFG_DW'(r_cfg.overdrive_level);
            apvo_pkg::REG_LOUD:       prdata = apvo_pkg::CFG_DW'(r_cfg.loudness);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step      <= apvo_pkg::RST_PHASE_STEP;
            r_cfg.decay_factor    <= apvo_pkg::RST_DECAY;
            r_cfg.overdrive_level <= apvo_pkg::RST_LEVEL;
            r_cfg.loudness        <= apvo_pkg::RST_LOUD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/apvo_sine_rom.sv =====
// Quarter-wave sine ROM, quadrant folding, registered magnitude and sign.
`default_nettype none

module apvo_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  wire logic                              i_clk,
    input  wire logic [TABLE_BITS+1:0]             i_phase_top,
    output logic signed [apvo_pkg::SINE_W-1:0]     o_sine
);

    localparam int ROM_N = 1 << TABLE_BITS;

    typedef logic [apvo_pkg::MAG_W-1:0] t_rom [0:ROM_N];

    function automatic t_rom build_rom();
        t_rom r;
        for (int i = 0; i <= ROM_N; i++) begin
            r[i] = apvo_pkg::sine_entry(i, TABLE_BITS);
        end
        return r;
    endfunction

    localparam t_rom ROM_TABLE = build_rom();

    logic [TABLE_BITS-1:0]         idx;
    logic [TABLE_BITS:0]           addr;
    logic [apvo_pkg::MAG_W-1:0]    r_mag;
    logic                          r_neg;
    logic signed [apvo_pkg::SINE_W-1:0] mag_s;

    assign idx  = i_phase_top[TABLE_BITS-1:0];
    assign addr = i_phase_top[TABLE_BITS] ? ((TABLE_BITS+1)'(ROM_N) - {1'b0, idx})
                                          : {1'b0, idx};

    always_ff @(posedge i_clk) begin
        r_mag <= ROM_TABLE[addr];
        r_neg <= i_phase_top[TABLE_BITS+1];
    end

    assign mag_s  = $signed({1'b0, r_mag});
    assign o_sine = r_neg ? -mag_s : mag_s;

endmodule

`default_nettype wire

// ===== hdl/apvo_mul.sv =====
// Shared signed multiplier with operand selection and a registered product.
`default_nettype none

module apvo_mul (
    input  wire logic                                  i_clk,
    input  wire apvo_pkg::t_mul_op                     i_op,
    input  wire logic signed [apvo_pkg::SINE_W-1:0]    i_sine,
    input  wire logic        [apvo_pkg::WEIGHT_W-1:0]  i_weight,
    input  wire logic signed [apvo_pkg::ACC_W-1:0]     i_acc,
    input  wire logic        [apvo_pkg::ENV_W-1:0]     i_env,
    input  wire logic signed [apvo_pkg::TONE_W-1:0]    i_tone,
    input  wire logic        [apvo_pkg::LOUD_W-1:0]    i_loud,
    input  wire logic        [apvo_pkg::DECAY_W-1:0]   i_decay,
    output logic signed      [apvo_pkg::PROD_W-1:0]    o_prod
);

    localparam int AW = apvo_pkg::OPA_W;
    localparam int BW = apvo_pkg::OPB_W;

    logic signed [AW-1:0]               op_a;
    logic signed [BW-1:0]               op_b;
    logic signed [apvo_pkg::PROD_W-1:0] r_prod;
    logic signed [apvo_pkg::PROD_W-1:0] n_prod;
    logic signed [AW-1:0]               tone_a;
    logic signed [BW-1:0]               tone_b;

    assign tone_a = {{(AW - apvo_pkg::TONE_W){i_tone[apvo_pkg::TONE_W-1]}}, i_tone};
    assign tone_b = {{(BW - apvo_pkg::TONE_W){i_tone[apvo_pkg::TONE_W-1]}}, i_tone};

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_op)
            apvo_pkg::MUL_HARM: begin
                op_a = {{(AW - apvo_pkg::SINE_W){i_sine[apvo_pkg::SINE_W-1]}}, i_sine};
                op_b = $signed(BW'(i_weight));
            end
            apvo_pkg::MUL_ENV: begin
                op_a = {{(AW - apvo_pkg::ACC_W){i_acc[apvo_pkg::ACC_W-1]}}, i_acc};
                op_b = $signed(BW'(i_env));
            end
            apvo_pkg::MUL_SQ: begin
                op_a = tone_a;
                op_b = tone_b;
            end
            apvo_pkg::MUL_CUBE: begin
                // The square is non-negative and below 2^33.
                op_a = r_prod[AW-1:0];
                op_b = tone_b;
            end
            apvo_pkg::MUL_GAIN: begin
                op_a = tone_a;
                op_b = $signed(BW'(i_loud));
            end
            apvo_pkg::MUL_DECAY: begin
                op_a = $signed(AW'(i_env));
                op_b = $signed(BW'(i_decay));
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        if (i_op == apvo_pkg::MUL_NONE) begin
            n_prod = r_prod;
        end else begin
            n_prod = op_a * op_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== hdl/apvo_ctrl.sv =====
// Sequencer that steps the shared multiplier through one sample.
`default_nettype none

module apvo_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_out_busy,
    input  wire logic        i_last_harm,
    output apvo_pkg::t_ctrl  o_ctrl
);

    apvo_pkg::t_state r_state;
    apvo_pkg::t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            apvo_pkg::S_IDLE:  if (i_in_valid) n_state = apvo_pkg::S_ROM;
            apvo_pkg::S_ROM:   n_state = apvo_pkg::S_MUL;
            apvo_pkg::S_MUL:   n_state = apvo_pkg::S_ACC;
            apvo_pkg::S_ACC:   n_state = i_last_harm ? apvo_pkg::S_ENV : apvo_pkg::S_MUL;
            apvo_pkg::S_ENV:   n_state = apvo_pkg::S_TONE;
            apvo_pkg::S_TONE:  n_state = apvo_pkg::S_SQ;
            apvo_pkg::S_SQ:    n_state = apvo_pkg::S_CUBE;
            apvo_pkg::S_CUBE:  n_state = apvo_pkg::S_SHAPE;
            apvo_pkg::S_SHAPE: n_state = apvo_pkg::S_CLAMP;
            apvo_pkg::S_CLAMP: n_state = apvo_pkg::S_GAIN;
            apvo_pkg::S_GAIN:  n_state = apvo_pkg::S_OUT;
            apvo_pkg::S_OUT:   if (!i_out_busy) n_state = apvo_pkg::S_DMUL;
            apvo_pkg::S_DMUL:  n_state = apvo_pkg::S_DECAY;
            apvo_pkg::S_DECAY: n_state = apvo_pkg::S_IDLE;
            default:           n_state = apvo_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl        = '0;
        o_ctrl.mul_op = apvo_pkg::MUL_NONE;
        case (r_state)
            apvo_pkg::S_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                o_ctrl.start    = i_in_valid;
            end
            apvo_pkg::S_MUL: begin
                o_ctrl.mul_op = apvo_pkg::MUL_HARM;
                o_ctrl.hp_adv = 1'b1;
            end
            apvo_pkg::S_ACC: begin
                o_ctrl.acc_add = 1'b1;
                o_ctrl.h_inc   = !i_last_harm;
            end
            apvo_pkg::S_ENV:   o_ctrl.mul_op   = apvo_pkg::MUL_ENV;
            apvo_pkg::S_TONE:  o_ctrl.tone_ld  = 1'b1;
            apvo_pkg::S_SQ:    o_ctrl.mul_op   = apvo_pkg::MUL_SQ;
            apvo_pkg::S_CUBE:  o_ctrl.mul_op   = apvo_pkg::MUL_CUBE;
            apvo_pkg::S_SHAPE: o_ctrl.shape_ld = 1'b1;
            apvo_pkg::S_CLAMP: o_ctrl.clamp_ld = 1'b1;
            apvo_pkg::S_GAIN:  o_ctrl.mul_op   = apvo_pkg::MUL_GAIN;
            apvo_pkg::S_OUT:   o_ctrl.out_ld   = !i_out_busy;
            apvo_pkg::S_DMUL:  o_ctrl.mul_op   = apvo_pkg::MUL_DECAY;
            apvo_pkg::S_DECAY: o_ctrl.env_upd  = 1'b1;
            default: begin
                o_ctrl        = '0;
                o_ctrl.mul_op = apvo_pkg::MUL_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apvo_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/additive_piano_voice_overdrive_core.sv =====
// Top level of the additive piano voice with cubic overdrive.
//
//   Channel   Dir   Handshake              Payload
//   i_in      in    valid/ready            note_start (1 bit)
//   o_out     out   valid/ready            sample (16 bit signed, Q1.15)
//   config    in    APB psel/penable       phase_step, decay_factor,
//                                          overdrive_level, loudness
//
// A sample is worked through from the input transfer until the block is ready
// again, with the single multiplier serving every harmonic and every gain stage.
// Reset clears the phase, loads the envelope with 1.0 and the registers with
// their defaults. A result that is not taken holds the sequencer before the
// envelope update, while the next input transfer is only taken once it is done.
`default_nettype none

module additive_piano_voice_overdrive_core #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int NUM_HARMONICS   = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    apvo_in_if.sink                            i_in,
    apvo_out_if.source                         o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [apvo_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [apvo_pkg::CFG_DW-1:0]   pwdata,
    output logic      [apvo_pkg::CFG_DW-1:0]   prdata,
    output logic                               pready
);

    localparam int HW     = $clog2(NUM_HARMONICS + 1);
    localparam int PW     = apvo_pkg::PROD_W;
    localparam int TW     = apvo_pkg::TONE_W;

    apvo_pkg::t_cfg  cfg;
    apvo_pkg::t_ctrl ctrl;

    logic [PHASE_BITS-1:0]              r_phase;
    logic [PHASE_BITS-1:0]              n_phase;
    logic [apvo_pkg::ENV_W-1:0]         r_env;
    logic [apvo_pkg::ENV_W-1:0]         n_env;
    logic [PHASE_BITS-1:0]              r_hp;
    logic [PHASE_BITS-1:0]              n_hp;
    logic [HW-1:0]                      r_h;
    logic [HW-1:0]                      n_h;
    logic signed [apvo_pkg::ACC_W-1:0]  r_acc;
    logic signed [apvo_pkg::ACC_W-1:0]  n_acc;
    logic signed [TW-1:0]               r_tone;
    logic signed [TW-1:0]               n_tone;
    logic signed [apvo_pkg::SINE_W-1:0] r_sample;
    logic signed [apvo_pkg::SINE_W-1:0] n_sample;
    logic                               r_out_valid;
    logic                               n_out_valid;

    logic signed [apvo_pkg::SINE_W-1:0] sine;
    logic signed [PW-1:0]               prod;
    logic [apvo_pkg::WEIGHT_W-1:0]      weight;
    logic                               last_harm;
    logic                               out_busy;
    logic signed [TW-1:0]               lim;
    logic signed [PW-1:0]               tone_round;
    logic signed [PW-1:0]               cube_round;
    logic signed [PW-1:0]               gain_round;

    apvo_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    apvo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_busy  (out_busy),
        .i_last_harm (last_harm),
        .o_ctrl      (ctrl)
    );

    apvo_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .i_clk       (i_clk),
        .i_phase_top (r_hp[PHASE_BITS-1 -: SINE_TABLE_BITS+2]),
        .o_sine      (sine)
    );

    apvo_mul u_mul (
        .i_clk    (i_clk),
        .i_op     (ctrl.mul_op),
        .i_sine   (sine),
        .i_weight (weight),
        .i_acc    (r_acc),
        .i_env    (r_env),
        .i_tone   (r_tone),
        .i_loud   (cfg.loudness),
        .i_decay  (cfg.decay_factor),
        .o_prod   (prod)
    );

    assign weight     = apvo_pkg::WEIGHT_TOP >> (r_h - HW'(1));
    assign last_harm  = (r_h == HW'(NUM_HARMONICS));
    assign out_busy   = r_out_valid && !o_out.ready;
    assign lim        = $signed({2'b00, cfg.overdrive_level});
    assign tone_round = apvo_pkg::rnd_shift(prod, 31);
    assign cube_round = apvo_pkg::rnd_shift(prod, 30);
    assign gain_round = apvo_pkg::rnd_shift(prod, 15);

    always_comb begin
        n_phase     = r_phase;
        n_env       = r_env;
        n_hp        = r_hp;
        n_h         = r_h;
        n_acc       = r_acc;
        n_tone      = r_tone;
        n_sample    = r_sample;
        n_out_valid = out_busy;

        if (ctrl.start) begin
            n_phase = i_in.note_start ? '0 : r_phase;
            n_env   = i_in.note_start ? apvo_pkg::ENV_ONE : r_env;
            n_hp    = i_in.note_start ? '0 : r_phase;
            n_h     = HW'(1);
            n_acc   = '0;
        end
        if (ctrl.hp_adv) begin
            n_hp = r_hp + r_phase;
        end
        if (ctrl.acc_add) begin
            n_acc = r_acc + prod[apvo_pkg::ACC_W-1:0];
            if (ctrl.h_inc) begin
                n_h = r_h + HW'(1);
            end
        end
        if (ctrl.tone_ld) begin
            n_tone = tone_round[TW-1:0];
        end
        if (ctrl.shape_ld) begin
            n_tone = r_tone + cube_round[TW-1:0];
        end
        if (ctrl.clamp_ld) begin
            if (r_tone >= lim) begin
                n_tone = lim;
            end else if (r_tone <= -lim) begin
                n_tone = -lim;
            end
        end
        if (ctrl.out_ld) begin
            if (gain_round > apvo_pkg::SAT_POS) begin
                n_sample = apvo_pkg::SAMPLE_POS;
            end else if (gain_round < apvo_pkg::SAT_NEG) begin
                n_sample = apvo_pkg::SAMPLE_NEG;
            end else begin
                n_sample = gain_round[apvo_pkg::SINE_W-1:0];
            end
            n_out_valid = 1'b1;
        end
        if (ctrl.env_upd) begin
            n_env   = prod[apvo_pkg::ENV_W+23:24];
            n_phase = r_phase + PHASE_BITS'(cfg.phase_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_env       <= apvo_pkg::ENV_ONE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_env       <= n_env;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hp     <= n_hp;
        r_h      <= n_h;
        r_acc    <= n_acc;
        r_tone   <= n_tone;
        r_sample <= n_sample;
    end

    assign i_in.ready   = ctrl.in_ready;
    assign o_out.valid  = r_out_valid;
    assign o_out.sample = r_sample;

endmodule

`default_nettype wire

// ===== tb/sv/tb_additive_piano_voice_overdrive_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the additive piano voice: a scoreboard predicts each sample.

class voice_scoreboard;
    localparam int TABLE_BITS = 10;
    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam int HARMONICS  = 6;

    apvo_pkg::t_cfg     regs;
    logic [31:0]        phase;
    logic [24:0]        env;
    int                 sine_mag[TABLE_SIZE+1];
    logic signed [15:0] pending_samples[$];
    int                 mismatches;

    function new();
        longint x;
        longint x2;
        longint term;
        longint s;
        longint v;
        int     i;
        int     k;
        for (i = 0; i <= TABLE_SIZE; i++) begin
            x = (longint'(1686629713) * i) >>> TABLE_BITS;
            x2 = (x * x) >>> 30;
            term = x;
            s = x;
            for (k = 1; k <= 7; k++) begin
                term = ((term * x2) >>> 30) / ((2 * k) * (2 * k + 1));
                s = (k % 2 == 1) ? s - term : s + term;
            end
            if (s < 0) begin
                s = 0;
            end
            v = (s * 32767 + (longint'(1) <<< 29)) >>> 30;
            sine_mag[i] = (v > 32767) ? 32767 : int'(v);
        end
        regs.phase_step      = apvo_pkg::RST_PHASE_STEP;
        regs.decay_factor    = apvo_pkg::RST_DECAY;
        regs.overdrive_level = apvo_pkg::RST_LEVEL;
        regs.loudness        = apvo_pkg::RST_LOUD;
        phase      = '0;
        env        = apvo_pkg::ENV_ONE;
        mismatches = 0;
    endfunction

    function void set_reg(apvo_pkg::t_reg_idx idx, logic [31:0] value);
        case (idx)
            apvo_pkg::REG_PHASE_STEP: regs.phase_step      = value;
            apvo_pkg::REG_DECAY:      regs.decay_factor    = value[23:0];
            apvo_pkg::REG_LEVEL:      regs.overdrive_level = value[18:0];
            apvo_pkg::REG_LOUD:       regs.loudness        = value[16:0];
            default: ;
        endcase
    endfunction

    // Rounds half away from zero while dividing by 2^n.
    function longint round_shift(longint v, int n);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) <<< (n - 1))) >>> n;
        return (v < 0) ? -mag : mag;
    endfunction

    function longint quarter_sine(logic [31:0] p);
        longint v;
        int     idx;
        idx = int'(p[29:20]);
        v = p[30] ? longint'(sine_mag[TABLE_SIZE - idx]) : longint'(sine_mag[idx]);
        return p[31] ? -v : v;
    endfunction

    function void note_accepted(logic note_start);
        longint      partials;
        longint      tone;
        longint      lim;
        longint      y;
        logic [31:0] p;
        int          h;
        if (note_start) begin
            phase = '0;
            env   = apvo_pkg::ENV_ONE;
        end
        partials = 0;
        for (h = 1; h <= HARMONICS; h++) begin
            p = phase * 32'(h);
            partials += quarter_sine(p) * longint'(128 >> (h - 1));
        end
        tone = round_shift(partials * longint'(env), 31);
        tone = tone + round_shift(tone * tone * tone, 30);
        lim  = longint'(regs.overdrive_level);
        if (tone >= lim) begin
            tone = lim;
        end else if (tone <= -lim) begin
            tone = -lim;
        end
        y = round_shift(tone * longint'(regs.loudness), 15);
        if (y > 32767) begin
            y = 32767;
        end else if (y < -32767) begin
            y = -32767;
        end
        pending_samples.push_back(16'(y));
        phase = phase + regs.phase_step;
        env   = 25'((longint'(env) * longint'(regs.decay_factor)) >>> 24);
    endfunction

    function void sample_received(logic signed [15:0] got);
        logic signed [15:0] want;
        if (pending_samples.size() == 0) begin
            $display("%0t: sample %0d arrived with none expected", $time, got);
            mismatches++;
        end else begin
            want = pending_samples.pop_front();
            if (got !== want) begin
                $display("%0t: sample mismatch, expected %0d, got %0d", $time, want, got);
                mismatches++;
            end
        end
    endfunction

    function int outstanding();
        return pending_samples.size();
    endfunction
endclass

module tb_additive_piano_voice_overdrive_core;

    localparam int CLK_HALF     = 5;
    localparam int SETTLE       = 40;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_SETS  = 10;
    localparam int NOTES_PER_SET = 150;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [apvo_pkg::CFG_AW-1:0] paddr;
    logic [apvo_pkg::CFG_DW-1:0] pwdata;
    logic [apvo_pkg::CFG_DW-1:0] prdata;
    logic                        pready;
    logic                        sink_stalls;
    int                          cycle_count;
    voice_scoreboard             sb;

    apvo_in_if  in_ch();
    apvo_out_if out_ch();

    additive_piano_voice_overdrive_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** additive_piano_voice_overdrive_core: FAILED **");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                sb.note_accepted(in_ch.note_start);
            end
            if (out_ch.valid && out_ch.ready) begin
                sb.sample_received(out_ch.sample);
            end
        end
    end

    always @(negedge clk) begin
        out_ch.ready <= sink_stalls ? ($urandom_range(99) >= 22) : 1'b1;
    end

    task automatic write_reg(input apvo_pkg::t_reg_idx idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_config(input logic [31:0] step, input logic [23:0] decay,
                                input logic [18:0] level, input logic [16:0] loud);
        write_reg(apvo_pkg::REG_PHASE_STEP, step);
        write_reg(apvo_pkg::REG_DECAY, 32'(decay));
        write_reg(apvo_pkg::REG_LEVEL, 32'(level));
        write_reg(apvo_pkg::REG_LOUD, 32'(loud));
    endtask

    task automatic send_notes(input int count, input int restart_pct, input bit with_gaps);
        int sent;
        sent = 0;
        @(negedge clk);
        while (sent < count) begin
            if (with_gaps && $urandom_range(99) < 22) begin
                in_ch.valid      <= 1'b0;
                in_ch.note_start <= 1'($urandom_range(1));
                @(negedge clk);
            end else begin
                in_ch.valid      <= 1'b1;
                in_ch.note_start <= ($urandom_range(99) < restart_pct);
                @(posedge clk);
                while (!in_ch.ready) @(posedge clk);
                sent++;
                @(negedge clk);
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_config();
        logic [31:0] step;
        logic [23:0] decay;
        logic [18:0] level;
        logic [16:0] loud;
        case ($urandom_range(3))
            0: step = $urandom_range(32'h0400_0000, 32'h0040_0000);
            1: step = $urandom_range(65535);
            default: step = $urandom;
        endcase
        case ($urandom_range(4))
            0: decay = 24'($urandom);
            1: decay = 24'hFF_FFFF;
            default: decay = 24'hFF_0000 | 24'($urandom_range(16'hFFFF));
        endcase
        case ($urandom_range(3))
            0: level = 19'($urandom);
            1: level = 19'(327680);
            default: level = 19'($urandom_range(327680));
        endcase
        loud = 17'($urandom);
        apply_config(step, decay, level, loud);
    endtask

    initial begin
        bit quiet;
        int set_no;
        clk              = 1'b0;
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_ch.valid      = 1'b0;
        in_ch.note_start = 1'b0;
        out_ch.ready     = 1'b0;
        sink_stalls      = 1'b1;
        cycle_count      = 0;
        sb               = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_notes(2, 0, 1'b1);
        drain();
        apply_config(32'h0100_0000, 24'hFF_FFFF, 19'(327680), 17'(65536));
        send_notes(1, 100, 1'b1);
        send_notes(6, 0, 1'b1);
        drain();
        // Zero decay with the widest clamp and gain; every sample of this set is zero.
        apply_config(32'hFFFF_FFFF, 24'h00_0000, 19'h7_FFFF, 17'h1_FFFF);
        send_notes(1, 100, 1'b0);
        send_notes(4, 0, 1'b0);
        drain();
        apply_config(32'h4000_0000, 24'hFF_FFFF, 19'd0, 17'd0);
        send_notes(4, 50, 1'b1);
        drain();
        apply_config(32'h0555_5555, 24'h80_0000, apvo_pkg::RST_LEVEL, apvo_pkg::RST_LOUD);
        send_notes(1, 100, 1'b1);
        send_notes(5, 0, 1'b1);
        drain();

        for (set_no = 0; set_no < RANDOM_SETS; set_no++) begin
            quiet       = (set_no == 4);
            sink_stalls = !quiet;
            random_config();
            send_notes(NOTES_PER_SET, $urandom_range(10, 2), !quiet);
            drain();
        end

        if (sb.mismatches == 0) begin
            $display("** additive_piano_voice_overdrive_core: PASSED **");
        end else begin
            $display("** additive_piano_voice_overdrive_core: FAILED **");
        end
        $finish;
    end
endmodule
